>>> rtl/core/ovst_pkg.sv
// Package for the ordered value set table: capacity, widths, operation and
// status codes, and the structs that run along the row of storage cells.
// Depends on nothing; every other file of the block imports it.
package ovst_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Broadcast to every cell for the comparison.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
  } ovst_cmp_t;

  // Broadcast to every cell for the update.
  typedef struct packed {
    logic ins;
    logic rem;
  } ovst_wr_t;

endpackage

>>> rtl/core/ordered_value_set_table.sv
// Top level of the ordered value set table: handshakes, operation register,
// count, result register and the row of ovst_cell storage cells.
// Depends on ovst_pkg and ovst_cell.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_mode, in_value   | in
//   result  | out_valid, out_stall, out_was_present,  | out
//           | out_status, out_count                   |
//
// Each beat is registered into the operation register at the accepting edge,
// and in its update cycle the cell row compares all entries at once, the hit
// ripples along the row and the entries shift or take the new value while
// the result is loaded. No new beat is taken before that update is done.
// A waiting result does not block acceptance of the next beat;
// only when the result register is still held by a stall does the update
// cycle wait, and in_stall stays high until it completes. Reset clears the
// count and the handshake state; the entries keep whatever they hold, since
// nothing at or above the count is ever read.
module ordered_value_set_table
  import ovst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_was_present,
  output logic [STATUS_W-1:0]       out_status,
  output logic [COUNT_W-1:0]        out_count
);

  // Operation register and control state.
  logic                      busy_r, busy_nxt;
  logic [MODE_W-1:0]         mode_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  // Result register.
  logic                      out_valid_r, out_valid_nxt;
  logic                      was_present_r;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic [COUNT_W-1:0]        count_r;

  logic                      in_take;
  logic                      fire;
  logic                      present;
  logic                      full;
  logic                      is_ins, is_rem;
  logic [CNT_W+COUNT_W-1:0]  cnt_ext;

  ovst_cmp_t                 cmp;
  ovst_wr_t                  wr;

  logic signed [VALUE_W-1:0] entry [CAPACITY];
  logic                      seen  [CAPACITY+1];

  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;

  // The update cycle may only proceed when the result register is free.
  assign fire    = busy_r && !(out_valid_r && out_stall);
  assign present = seen[CAPACITY];
  assign full    = (cnt_r == CNT_W'(CAPACITY));

  // Mode three is treated as a query.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (mode_r)
      MODE_INSERT: is_ins = 1'b1;
      MODE_REMOVE: is_rem = 1'b1;
      default:     ;
    endcase
  end

  assign cmp.value = value_r;
  assign cmp.count = cnt_r;
  assign wr.ins    = fire && is_ins && !present && !full;
  assign wr.rem    = fire && is_rem && present;

  always_comb begin
    status_nxt = ST_DONE;
    if (is_ins) begin
      if (present) begin
        status_nxt = ST_SAME;
      end else if (full) begin
        status_nxt = ST_FULL;
      end
    end else if (is_rem && !present) begin
      status_nxt = ST_SAME;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (wr.rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // The reported count is the new count taken to the width of the port.
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    busy_nxt = busy_r;
    if (in_take) begin
      busy_nxt = 1'b1;
    end else if (fire) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  // The hit ripples along the row; a cell shifts once the hit has been seen.
  assign seen[0] = 1'b0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VALUE_W-1:0] nbr;
    if (k == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry[k+1];
    end
    ovst_cell u_cell (
      .clk       (clk),
      .idx       (CNT_W'(k)),
      .cmp       (cmp),
      .wr        (wr),
      .nbr_entry (nbr),
      .seen_in   (seen[k]),
      .entry     (entry[k]),
      .seen_out  (seen[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
    if (fire) begin
      was_present_r <= present;
      status_r      <= status_nxt;
      count_r       <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_present = was_present_r;
  assign out_status      = status_r;
  assign out_count       = count_r;

endmodule

>>> rtl/core/ovst_cell.sv
// One storage cell of the ordered value set table: holds one entry, compares
// it with the broadcast value, loads that value on an insert at the count
// and takes its right-hand neighbour on a remove. Depends on ovst_pkg.
module ovst_cell
  import ovst_pkg::*;
(
  input  logic                      clk,
  input  logic [CNT_W-1:0]          idx,
  input  ovst_cmp_t                 cmp,
  input  ovst_wr_t                  wr,
  input  logic signed [VALUE_W-1:0] nbr_entry,
  input  logic                      seen_in,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      seen_out
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      match;

  assign match    = (idx < cmp.count) && (entry_r == cmp.value);
  assign seen_out = seen_in | match;
  assign entry    = entry_r;

  // A remove closes the gap: this cell and all after the hit take the next one.
  always_comb begin
    entry_nxt = entry_r;
    if (wr.ins && (idx == cmp.count)) begin
      entry_nxt = cmp.value;
    end else if (wr.rem && seen_out) begin
      entry_nxt = nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> rtl/core/ovst_checker.sv
// Port-level checker for the ordered value set table, bound to the top level.
// Depends on ovst_pkg and on the ports of ordered_value_set_table.
module ovst_checker
  import ovst_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [MODE_W-1:0]         in_mode,
  input logic signed [VALUE_W-1:0] in_value,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_was_present,
  input logic [STATUS_W-1:0]       out_status,
  input logic [COUNT_W-1:0]        out_count
);

  // An accepted beat occupies the block for its update cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  // A stalled input beat keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_mode) && $stable(in_value)))
    else $error("stalled input beat changed");

  // A refused insert is only reported for a new value in a full table.
  a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> !out_was_present)
    else $error("full refusal for a present value");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |->
      (out_count == COUNT_W'(CAPACITY)))
    else $error("full refusal below capacity");

  // A result waiting under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_count)
       && $stable(out_was_present)))
    else $error("stalled result changed");

endmodule

bind ordered_value_set_table ovst_checker u_ovst_checker (.*);
